// ===== sv/dpcp_pkg.sv =====
`timescale 1ns / 1ps

package dpcp_pkg;

    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned DataW   = 8;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ON_TICKS    = 2'd0,
        CFG_OFF_TICKS   = 2'd1,
        CFG_MAX_COUNT   = 2'd2,
        CFG_HALF_PERIOD = 2'd3
    } t_cfg_idx;

    localparam logic [DataW-1:0] RST_ON_TICKS    = 8'd3;
    localparam logic [DataW-1:0] RST_OFF_TICKS   = 8'd3;
    localparam logic [DataW-1:0] RST_MAX_COUNT   = 8'd100;
    localparam logic [DataW-1:0] RST_HALF_PERIOD = 8'd50;
    localparam logic [DataW-1:0] MAX_HALF_PERIOD = 8'd128;

    typedef struct packed {
        logic [DataW-1:0] on_ticks;
        logic [DataW-1:0] off_ticks;
        logic [DataW-1:0] max_count;
        logic [DataW-1:0] half_period;
    } t_cfg;

    // debounce result for one tick, plus the count before the tick for the LED
    typedef struct packed {
        logic             held;
        logic             fresh;
        logic [DataW-1:0] count_next;
        logic [DataW-1:0] count_cur;
    } t_db_stat;

    function automatic logic [DataW-1:0] at_least_one(input logic [DataW-1:0] v);
        return (v == '0) ? DataW'(1) : v;
    endfunction

endpackage

// ===== sv/debounced_press_counter_pwm.sv =====
`timescale 1ns / 1ps

// Debounced button press counter with a PWM LED output.
// Input channel: one transfer per timer tick on i_valid/o_ready, carrying
// the sampled level i_button_level. Output channel: one result per tick on
// o_valid/i_ready with o_led_on, o_press_count, o_new_press and o_pressed.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (on_ticks, off_ticks, max_count, half_period) in the same edge; write
// only while no tick is in flight.
// Latency: the result of a tick is valid in the cycle after its transfer.
// Throughput: one tick per cycle. The debounce and phase state advance in
// the accepting cycle, and a single output register holds the result.
// A stalled receiver holds the output register; o_ready stays high as long
// as the held result is taken in the same cycle, so the input stalls only
// when the output register is full and i_ready is low.
// Reset (synchronous, active low) loads the register defaults, clears the
// runs, the debounced state, the count and the LED phase, and empties the
// output register.
module debounced_press_counter_pwm
    import dpcp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DataW-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_button_level,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_led_on,
    output logic [DataW-1:0]   o_press_count,
    output logic               o_new_press,
    output logic               o_pressed
);

    t_cfg             r_cfg;
    t_db_stat         db_stat;
    logic             led;
    logic             step;
    logic             r_valid;
    logic             r_led;
    logic [DataW-1:0] r_count;
    logic             r_new;
    logic             r_pressed;

    assign o_ready = !r_valid || i_ready;
    assign step    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_ticks    <= RST_ON_TICKS;
            r_cfg.off_ticks   <= RST_OFF_TICKS;
            r_cfg.max_count   <= RST_MAX_COUNT;
            r_cfg.half_period <= RST_HALF_PERIOD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ON_TICKS:    r_cfg.on_ticks    <= i_cfg_data;
                CFG_OFF_TICKS:   r_cfg.off_ticks   <= i_cfg_data;
                CFG_MAX_COUNT:   r_cfg.max_count   <= i_cfg_data;
                CFG_HALF_PERIOD: r_cfg.half_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpcp_debounce u_debounce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_step  (step),
        .i_level (i_button_level),
        .o_stat  (db_stat)
    );

    // LED uses the count from before this tick's debounce update
    dpcp_pwm u_pwm (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_cfg.half_period),
        .i_step        (step),
        .i_count       (db_stat.count_cur),
        .o_led         (led)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_led     <= led;
            r_count   <= db_stat.count_next;
            r_new     <= db_stat.fresh;
            r_pressed <= db_stat.held;
        end
    end

    assign o_valid       = r_valid;
    assign o_led_on      = r_led;
    assign o_press_count = r_count;
    assign o_new_press   = r_new;
    assign o_pressed     = r_pressed;

    a_new_implies_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_new) |-> r_pressed)
        else $error("new press reported while released");

    a_count_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (db_stat.count_cur >= $past(db_stat.count_cur)))
        else $error("press count decreased");

    a_fresh_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(step) && $past(db_stat.fresh)) |-> (r_new && r_pressed))
        else $error("new press not reported as a pressed result");

endmodule

// ===== sv/dpcp_debounce.sv =====
`timescale 1ns / 1ps

module dpcp_debounce
    import dpcp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_step,
    input  logic     i_level,
    output t_db_stat o_stat
);

    logic [DataW-1:0] r_high_run, n_high_run;
    logic [DataW-1:0] r_low_run,  n_low_run;
    logic             r_held,     n_held;
    logic [DataW-1:0] r_count,    n_count;
    logic [DataW-1:0] on_thr, off_thr;
    logic             fresh;

    always_comb begin
        on_thr     = at_least_one(i_cfg.on_ticks);
        off_thr    = at_least_one(i_cfg.off_ticks);
        n_high_run = r_high_run;
        n_low_run  = r_low_run;
        n_held     = r_held;
        n_count    = r_count;
        fresh      = 1'b0;

        // runs saturate at their threshold
        if (i_level) begin
            if (r_high_run < on_thr) n_high_run = r_high_run + 1'b1;
            n_low_run = '0;
        end else begin
            n_high_run = '0;
            if (r_low_run < off_thr) n_low_run = r_low_run + 1'b1;
        end

        // press wins over release
        if (n_high_run >= on_thr) begin
            if (!r_held) begin
                n_held = 1'b1;
                fresh  = 1'b1;
                if (r_count < i_cfg.max_count) n_count = r_count + 1'b1;
            end
        end else if (n_low_run >= off_thr) begin
            n_held = 1'b0;
        end

        o_stat.held       = n_held;
        o_stat.fresh      = fresh;
        o_stat.count_next = n_count;
        o_stat.count_cur  = r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_run <= '0;
            r_low_run  <= '0;
            r_held     <= 1'b0;
            r_count    <= '0;
        end else if (i_step) begin
            r_high_run <= n_high_run;
            r_low_run  <= n_low_run;
            r_held     <= n_held;
            r_count    <= n_count;
        end
    end

endmodule

// ===== sv/dpcp_pwm.sv =====
`timescale 1ns / 1ps

module dpcp_pwm
    import dpcp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [DataW-1:0] i_half_period,
    input  logic             i_step,
    input  logic [DataW-1:0] i_count,
    output logic             o_led
);

    logic [DataW-1:0] r_phase, n_phase;
    logic [DataW-1:0] hp;
    logic [DataW:0]   two_hp;
    logic [DataW-1:0] p;
    logic [DataW:0]   p_inc;
    logic [DataW:0]   count_up;

    always_comb begin
        hp = at_least_one(i_half_period);
        if (hp > MAX_HALF_PERIOD) hp = MAX_HALF_PERIOD;
        two_hp = {hp, 1'b0};

        // restart a phase left out of range by a register change
        p = ({1'b0, r_phase} >= two_hp) ? '0 : r_phase;

        count_up = {1'b0, i_count} + 1'b1;
        if (p < hp) begin
            o_led = (count_up[DataW:1] > p);
        end else begin
            o_led = ((i_count >> 1) > (p - hp));
        end

        p_inc   = {1'b0, p} + 1'b1;
        n_phase = (p_inc >= two_hp) ? '0 : p_inc[DataW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
        end
    end

endmodule
